// ===== hw/rtl/lms_adaptive_fir_assert.svh =====
// assertion macros for the lms adaptive fir block
// implication in the same cycle and in the next cycle, reset disables both
`ifndef LMS_ADAPTIVE_FIR_ASSERT_SVH
`define LMS_ADAPTIVE_FIR_ASSERT_SVH

`define LMSFIR_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define LMSFIR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/lmsfir_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmsfir_pkg
// shared widths, reset constant and controller/datapath interface structs
// ----------------------------------------------------------------------------
package lmsfir_pkg;

    localparam int SampleW = 16;
    localparam int WeightW = 32;
    localparam int OutW    = 32;
    localparam int MuW     = 24;

    localparam logic [MuW-1:0] StepReset = 24'd3355;

    // commands from the controller to the datapath
    typedef struct packed {
        logic load;      // take a new sample and desired value
        logic rot;       // rotate delay line and weights by one place
        logic mul_upd;   // multiplier operand: step product instead of weight
        logic acc_en;    // add the registered product to the accumulator
        logic wupd;      // add the registered product to the tail weight
        logic calc_y;
        logic calc_e;
        logic calc_p;
        logic out_load;  // move y and e into the output register
    } t_cmd;

    // status from the datapath to the controller
    typedef struct packed {
        logic out_stall; // output register holds a beat not yet taken
    } t_sts;

endpackage

// ===== hw/rtl/lms_adaptive_fir.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lms_adaptive_fir
// least-mean-squares adaptive fir filter, controller plus shared-mac datapath
// ----------------------------------------------------------------------------
// Each input beat carries one sample and one desired value; each gives exactly
// one output beat with the filter output y (signed q24.8, saturated) and the
// error e = desired*256 - y (saturated). Weights are q8.24 and start at zero;
// step_size (unsigned q0.24, reset 3355) is written through i_cfg_we and
// i_cfg_wdata; the user must write it only while the block is idle, as the
// block itself does not enforce this. One multiplier is shared by the TAPS
// filter products and the TAPS weight update products, and the delay line and
// weights rotate past it one tap a cycle. The block takes no new input beat
// until its item is through. A finished result waits in the output register,
// so the next input beat is taken while it is still pending.
module lms_adaptive_fir #(
    parameter int TAPS = 5
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // input channel
    input  logic                                   i_in_valid,
    output logic                                   o_in_ready,
    input  logic signed [lmsfir_pkg::SampleW-1:0]  i_sample,
    input  logic signed [lmsfir_pkg::SampleW-1:0]  i_desired,
    // step size register
    input  logic                                   i_cfg_we,
    input  logic        [lmsfir_pkg::MuW-1:0]      i_cfg_wdata,
    // output channel
    output logic                                   o_out_valid,
    input  logic                                   i_out_ready,
    output logic signed [lmsfir_pkg::OutW-1:0]     o_filter_out,
    output logic signed [lmsfir_pkg::OutW-1:0]     o_error_out
);

    // command and status between sequencer and datapath
    lmsfir_pkg::t_cmd cmd;
    lmsfir_pkg::t_sts sts;

    // sequencer: filter pass, y, e, step product, update pass, output load
    lmsfir_ctrl #(
        .TAPS       (TAPS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // datapath: rotating delay line and weights, shared mac, output register
    lmsfir_dp #(
        .TAPS         (TAPS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_sample     (i_sample),
        .i_desired    (i_desired),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_out_ready  (i_out_ready),
        .o_out_valid  (o_out_valid),
        .o_filter_out (o_filter_out),
        .o_error_out  (o_error_out),
        .i_cmd        (cmd),
        .o_sts        (sts)
    );

endmodule

// ===== hw/rtl/lmsfir_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmsfir_ctrl
// sequencer for one item: filter pass, error and step, weight update pass
// ----------------------------------------------------------------------------
module lmsfir_ctrl #(
    parameter int TAPS = 5
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  lmsfir_pkg::t_sts  i_sts,
    output lmsfir_pkg::t_cmd  o_cmd
);

    localparam int CntW = (TAPS > 1) ? $clog2(TAPS) : 1;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_FILT   = 4'd1;
    localparam logic [3:0] S_FACC   = 4'd2;
    localparam logic [3:0] S_YCALC  = 4'd3;
    localparam logic [3:0] S_ECALC  = 4'd4;
    localparam logic [3:0] S_PCALC  = 4'd5;
    localparam logic [3:0] S_UPD    = 4'd6;
    localparam logic [3:0] S_UFLUSH = 4'd7;
    localparam logic [3:0] S_DONE   = 4'd8;

    logic [3:0]      r_state, n_state;
    logic [CntW-1:0] r_cnt, n_cnt;
    logic            last_tap;

    assign last_tap   = (r_cnt == CntW'(TAPS - 1));
    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                n_cnt = '0;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_FILT;
                end
            end
            S_FILT: begin
                o_cmd.rot    = 1'b1;
                o_cmd.acc_en = (r_cnt != '0);
                n_cnt        = r_cnt + 1'b1;
                if (last_tap) begin
                    n_cnt   = '0;
                    n_state = S_FACC;
                end
            end
            S_FACC: begin
                o_cmd.acc_en = 1'b1;
                n_state      = S_YCALC;
            end
            S_YCALC: begin
                o_cmd.calc_y = 1'b1;
                n_state      = S_ECALC;
            end
            S_ECALC: begin
                o_cmd.calc_e = 1'b1;
                n_state      = S_PCALC;
            end
            S_PCALC: begin
                o_cmd.calc_p = 1'b1;
                n_state      = S_UPD;
            end
            S_UPD: begin
                o_cmd.rot     = 1'b1;
                o_cmd.mul_upd = 1'b1;
                o_cmd.wupd    = (r_cnt != '0);
                n_cnt         = r_cnt + 1'b1;
                if (last_tap) begin
                    n_cnt   = '0;
                    n_state = S_UFLUSH;
                end
            end
            S_UFLUSH: begin
                o_cmd.wupd = 1'b1;
                if (!i_sts.out_stall) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!i_sts.out_stall) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

endmodule

// ===== hw/rtl/lmsfir_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmsfir_dp
// rotating delay line and weights, shared multiplier, accumulator, output reg
// ----------------------------------------------------------------------------
module lmsfir_dp #(
    parameter int TAPS = 5
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic signed [lmsfir_pkg::SampleW-1:0]    i_sample,
    input  logic signed [lmsfir_pkg::SampleW-1:0]    i_desired,
    input  logic                                     i_cfg_we,
    input  logic        [lmsfir_pkg::MuW-1:0]        i_cfg_wdata,
    input  logic                                     i_out_ready,
    output logic                                     o_out_valid,
    output logic signed [lmsfir_pkg::OutW-1:0]       o_filter_out,
    output logic signed [lmsfir_pkg::OutW-1:0]       o_error_out,
    input  lmsfir_pkg::t_cmd                         i_cmd,
    output lmsfir_pkg::t_sts                         o_sts
);

    localparam int SW   = lmsfir_pkg::SampleW;
    localparam int WW   = lmsfir_pkg::WeightW;
    localparam int PW   = 48;                   // rounded step product mu*e
    localparam int AccW = 48 + $clog2(TAPS);    // sum of weight*sample products

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        if (v > 66'sd2147483647) begin
            return 32'sh7fffffff;
        end else if (v < -66'sd2147483648) begin
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    logic signed [SW-1:0]   r_line [TAPS];
    logic signed [SW-1:0]   n_line [TAPS];
    logic signed [WW-1:0]   r_w    [TAPS];
    logic signed [WW-1:0]   n_w    [TAPS];
    logic signed [SW-1:0]   r_desired;
    logic [lmsfir_pkg::MuW-1:0] r_mu;
    logic signed [AccW-1:0] r_acc;
    logic signed [63:0]     r_prod;
    logic signed [31:0]     r_y, r_e;
    logic signed [PW-1:0]   r_p;
    logic                   r_out_valid;
    logic signed [31:0]     r_out_y, r_out_e;

    logic signed [PW-1:0]   mul_a;
    logic signed [63:0]     mul_full;
    logic signed [AccW:0]   acc_rnd;
    logic signed [AccW:0]   acc_sh;
    logic signed [65:0]     e_full;
    logic signed [57:0]     mu_e;
    logic signed [57:0]     mu_e_sh;
    logic signed [WW-1:0]   w_tail_upd;

    // one shared multiplier: weight * sample in the filter pass,
    // step product * sample in the update pass
    assign mul_a    = i_cmd.mul_upd ? r_p : PW'(r_w[0]);
    assign mul_full = 64'(mul_a) * 64'(r_line[0]);

    // round half up to q24.8
    assign acc_rnd = (AccW+1)'(r_acc) + (AccW+1)'(32'sd32768);
    assign acc_sh  = acc_rnd >>> 16;

    assign e_full  = (66'(r_desired) <<< 8) - 66'(r_y);

    assign mu_e    = 58'(signed'({1'b0, r_mu})) * 58'(r_e);
    assign mu_e_sh = (mu_e + 58'sd128) >>> 8;

    assign w_tail_upd = sat32(66'(r_w[TAPS-1]) + 66'(r_prod));

    always_comb begin
        n_line = r_line;
        n_w    = r_w;
        if (i_cmd.load) begin
            n_line[0] = i_sample;
            for (int k = 1; k < TAPS; k++) begin
                n_line[k] = r_line[k-1];
            end
        end else if (i_cmd.rot) begin
            for (int k = 0; k < TAPS - 1; k++) begin
                n_line[k] = r_line[k+1];
            end
            n_line[TAPS-1] = r_line[0];
        end
        if (i_cmd.rot) begin
            for (int k = 0; k < TAPS - 1; k++) begin
                n_w[k] = r_w[k+1];
            end
            n_w[TAPS-1] = r_w[0];
            // the tap whose product is pending sits at the tail before the move
            if (i_cmd.wupd) begin
                n_w[TAPS-2] = w_tail_upd;
            end
        end else if (i_cmd.wupd) begin
            n_w[TAPS-1] = w_tail_upd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < TAPS; k++) begin
                r_line[k] <= '0;
                r_w[k]    <= '0;
            end
            r_mu        <= lmsfir_pkg::StepReset;
            r_out_valid <= 1'b0;
        end else begin
            r_line <= n_line;
            r_w    <= n_w;
            if (i_cfg_we) begin
                r_mu <= i_cfg_wdata;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_full;
        if (i_cmd.load) begin
            r_desired <= i_desired;
            r_acc     <= '0;
        end else if (i_cmd.acc_en) begin
            r_acc <= r_acc + AccW'(r_prod);
        end
        if (i_cmd.calc_y) begin
            r_y <= sat32(66'(acc_sh));
        end
        if (i_cmd.calc_e) begin
            r_e <= sat32(e_full);
        end
        if (i_cmd.calc_p) begin
            r_p <= mu_e_sh[PW-1:0];
        end
        if (i_cmd.out_load) begin
            r_out_y <= r_y;
            r_out_e <= r_e;
        end
    end

    assign o_sts.out_stall = r_out_valid && !i_out_ready;
    assign o_out_valid     = r_out_valid;
    assign o_filter_out    = r_out_y;
    assign o_error_out     = r_out_e;

endmodule

// ===== hw/rtl/lmsfir_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmsfir_checker
// port-level checks of the lms adaptive fir, bound to the top level
// ----------------------------------------------------------------------------
`include "lms_adaptive_fir_assert.svh"

module lmsfir_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [31:0] o_filter_out,
    input logic [31:0] o_error_out
);

    // a stalled output beat holds
    `LMSFIR_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_filter_out) && $stable(o_error_out), "output beat changed while stalled")

    // one item at a time: the block is busy after taking a beat
    `LMSFIR_ASSERT_NEXT(a_busy_after_in, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_in_ready, "input taken while an item is in work")

    // an idle block with nothing pending does not invent a result
    `LMSFIR_ASSERT_NEXT(a_no_spurious_out, i_clk, i_rst_n, o_in_ready && !o_out_valid && !(i_in_valid && o_in_ready), !o_out_valid, "result without an input beat")

    // a result never appears in the cycle right after an input beat
    `LMSFIR_ASSERT_NEXT(a_no_early_out, i_clk, i_rst_n, i_in_valid && o_in_ready && !o_out_valid, !o_out_valid, "result too early after input beat")

endmodule

bind lms_adaptive_fir lmsfir_checker u_lmsfir_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in_valid),
    .o_in_ready   (o_in_ready),
    .o_out_valid  (o_out_valid),
    .i_out_ready  (i_out_ready),
    .o_filter_out (o_filter_out),
    .o_error_out  (o_error_out)
);

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the lms adaptive fir filter
// ----------------------------------------------------------------------------
// A bit-true predictor of the filter runs beside the block. It holds its own
// delay line, tap weights and step size. Every beat taken on the input
// channel is run through it, and the filter output and error it works out are
// queued. Each beat on the output channel is compared field by field with the
// oldest queued result.
// The directed part covers sample and desired extremes, saturation of the
// weights, of y and of e, and a zero step size with the weights frozen. The
// random part sweeps the step size across its range, including both ends.
// Its data comes in bursts of full-scale, mid-scale and small-scale values,
// and in bursts where desired follows the previous sample, so that the
// weights actually converge. Both sides idle at random. One phase holds the
// receiver off long enough to back the block up onto its input.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int TAP_COUNT       = 5;
    localparam int CYCLES_PER_ITEM = 2 * TAP_COUNT + 6;
    localparam int MAX_IDLE        = 18;
    localparam int HOLD_CYCLES     = 150;
    localparam int WATCHDOG_LIMIT  = 1000;

    typedef logic signed [lmsfir_pkg::SampleW-1:0] t_pcm;
    typedef logic signed [lmsfir_pkg::OutW-1:0]    t_q24_8;

    typedef struct packed {
        t_q24_8 y;
        t_q24_8 e;
    } t_y_e_pair;

    // block ports
    logic                           i_clk = 1'b0;
    logic                           i_rst_n;
    logic                           i_in_valid;
    logic                           o_in_ready;
    t_pcm                           i_sample;
    t_pcm                           i_desired;
    logic                           i_cfg_we;
    logic [lmsfir_pkg::MuW-1:0]     i_cfg_wdata;
    logic                           o_out_valid;
    logic                           i_out_ready;
    t_q24_8                         o_filter_out;
    t_q24_8                         o_error_out;

    // predictor state: history entry k-1 holds the sample from k beats ago
    t_pcm                           fir_hist [TAP_COUNT-1];
    logic signed [lmsfir_pkg::WeightW-1:0] fir_weights [TAP_COUNT];
    logic [lmsfir_pkg::MuW-1:0]     fir_step;

    t_y_e_pair          due_results [$];
    int                 fail_count;
    int                 beats_out;
    int                 quiet_cycles;

    // idling controls for the sender and the receiver
    bit                 tx_idle_on;
    bit                 rx_idle_on;
    int                 rx_hold_cycles;

    lms_adaptive_fir #(
        .TAPS         (TAP_COUNT)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_sample     (i_sample),
        .i_desired    (i_desired),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_filter_out (o_filter_out),
        .o_error_out  (o_error_out)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------------
    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647) begin
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648) begin
            return -64'sd2147483648;
        end
        return v;
    endfunction

    task automatic clear_filter_state();
        for (int k = 0; k < TAP_COUNT - 1; k++) begin
            fir_hist[k] = '0;
        end
        for (int k = 0; k < TAP_COUNT; k++) begin
            fir_weights[k] = '0;
        end
        fir_step = lmsfir_pkg::StepReset;
    endtask

    // one filter step: y from the old weights, then adapt with the new line
    task automatic filter_and_adapt(input t_pcm smp, input t_pcm des);
        longint    line [TAP_COUNT];
        longint    acc;
        longint    y;
        longint    e;
        longint    p;
        t_y_e_pair r;
        line[0] = smp;
        for (int k = 1; k < TAP_COUNT; k++) begin
            line[k] = fir_hist[k-1];
        end
        acc = 0;
        for (int k = 0; k < TAP_COUNT; k++) begin
            acc += longint'(fir_weights[k]) * line[k];
        end
        // round half up from q.24 to q24.8, arithmetic shift floors
        y = clamp32((acc + 64'sd32768) >>> 16);
        e = clamp32(longint'(des) * 256 - y);
        p = (longint'(fir_step) * e + 64'sd128) >>> 8;
        for (int k = 0; k < TAP_COUNT; k++) begin
            fir_weights[k] = lmsfir_pkg::WeightW'(
                clamp32(longint'(fir_weights[k]) + p * line[k]));
        end
        for (int k = 0; k < TAP_COUNT - 1; k++) begin
            fir_hist[k] = lmsfir_pkg::SampleW'(line[k]);
        end
        r.y = y[lmsfir_pkg::OutW-1:0];
        r.e = e[lmsfir_pkg::OutW-1:0];
        due_results.push_back(r);
    endtask

    // ------------------------------------------------------------------------
    // checking
    // ------------------------------------------------------------------------
    task automatic report_mismatch(input string what, input longint got,
                                   input longint want);
        $display("tb_top: mismatch at output beat %0d: %s got %0d want %0d",
                 beats_out, what, got, want);
        fail_count++;
    endtask

    always @(posedge i_clk) begin
        t_y_e_pair want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (due_results.size() == 0) begin
                report_mismatch("beat with nothing pending, filter_out",
                                o_filter_out, 0);
            end else begin
                want = due_results.pop_front();
                if (o_filter_out !== want.y) begin
                    report_mismatch("filter_out", o_filter_out, want.y);
                end
                if (o_error_out !== want.e) begin
                    report_mismatch("error_out", o_error_out, want.e);
                end
            end
            beats_out++;
        end
    end

    // watchdog on cycles with no beat on either channel
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // receiver: random stall per beat, plus a long hold when one is requested
    // ------------------------------------------------------------------------
    initial begin
        int gap;
        i_out_ready = 1'b0;
        wait (i_rst_n);
        forever begin
            @(negedge i_clk);
            if (rx_hold_cycles > 0) begin
                i_out_ready = 1'b0;
                repeat (rx_hold_cycles) @(negedge i_clk);
                rx_hold_cycles = 0;
            end
            gap = rx_idle_on ? $urandom_range(MAX_IDLE, 0) : 0;
            if (gap > 0) begin
                i_out_ready = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            i_out_ready = 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    // ------------------------------------------------------------------------
    // sender side helpers, all called at a falling edge
    // ------------------------------------------------------------------------
    // valid stays high after a beat so back-to-back beats need no toggle;
    // wait_idle drops it at the end of each phase
    task automatic send_beat(input t_pcm smp, input t_pcm des);
        int gap;
        gap = tx_idle_on ? $urandom_range(MAX_IDLE, 0) : 0;
        if (gap > 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_sample   = smp;
        i_desired  = des;
        i_in_valid = 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        filter_and_adapt(smp, des);
        @(negedge i_clk);
    endtask

    task automatic wait_idle();
        i_in_valid = 1'b0;
        while (due_results.size() != 0) @(posedge i_clk);
        repeat (CYCLES_PER_ITEM + 4) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_step(input logic [lmsfir_pkg::MuW-1:0] mu);
        i_cfg_we    = 1'b1;
        i_cfg_wdata = mu;
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
        fir_step    = mu;
    endtask

    function automatic t_pcm draw_span(int bits);
        int v;
        if (bits >= lmsfir_pkg::SampleW) begin
            // rails now and then, otherwise every bit pattern
            case ($urandom_range(15, 0))
                0: return 16'sh7fff;
                1: return 16'sh8000;
                2: return 16'sh0000;
                3: return 16'shffff;
                default: return t_pcm'($urandom);
            endcase
        end
        v = $urandom_range((1 << bits) - 1, 0);
        v = v - (1 << (bits - 1));
        return v[lmsfir_pkg::SampleW-1:0];
    endfunction

    // bursts of one data shape each; correlated bursts let the weights settle
    task automatic send_random(input int count, input bit allow_idle);
        int   left;
        int   burst;
        int   shape;
        int   bits;
        t_pcm smp;
        t_pcm des;
        t_pcm prev;
        left = count;
        prev = '0;
        while (left > 0) begin
            burst = $urandom_range(64, 8);
            if (burst > left) begin
                burst = left;
            end
            shape = $urandom_range(3, 0);
            bits  = $urandom_range(10, 7);
            tx_idle_on = allow_idle && ($urandom_range(3, 0) != 0);
            rx_idle_on = allow_idle && ($urandom_range(3, 0) != 0);
            repeat (burst) begin
                case (shape)
                    0: begin
                        smp = draw_span(lmsfir_pkg::SampleW);
                        des = draw_span(lmsfir_pkg::SampleW);
                    end
                    1: begin
                        smp = draw_span(bits);
                        des = draw_span(bits);
                    end
                    2: begin
                        smp = draw_span(3);
                        des = draw_span(3);
                    end
                    default: begin
                        smp = draw_span(bits);
                        des = (prev >>> 1) + draw_span(3);
                    end
                endcase
                send_beat(smp, des);
                prev = smp;
            end
            left -= burst;
        end
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
    endtask

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------
    // rails and sign combinations with the reset step size
    task automatic test_extremes();
        t_pcm smp [12] = '{16'sh0000, 16'sh7fff, 16'sh8000, 16'sh0000,
                           16'sh0000, 16'sh7fff, 16'sh8000, 16'sh7fff,
                           16'sh8000, 16'sh0001, 16'shffff, 16'shffff};
        t_pcm des [12] = '{16'sh0000, 16'sh0000, 16'sh0000, 16'sh7fff,
                           16'sh8000, 16'sh7fff, 16'sh8000, 16'sh8000,
                           16'sh7fff, 16'shffff, 16'sh0001, 16'shffff};
        for (int i = 0; i < 12; i++) begin
            send_beat(smp[i], des[i]);
        end
        wait_idle();
    endtask

    // full step drives weights, y and e onto their rails; zero step freezes
    task automatic test_saturation();
        t_pcm smp [8] = '{16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh7fff,
                          16'sh8000, 16'sh8000, 16'sh7fff, 16'sh0000};
        t_pcm des [8] = '{16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000,
                          16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh0000};
        write_step(24'hffffff);
        for (int i = 0; i < 8; i++) begin
            send_beat(smp[i], des[i]);
        end
        wait_idle();
        write_step(24'h000000);
        send_beat(16'sd12345, -16'sd12345);
        send_beat(-16'sd1, 16'sd0);
        send_beat(16'sh7fff, 16'sh8000);
        wait_idle();
    endtask

    task automatic test_reset_step_random();
        write_step(lmsfir_pkg::StepReset);
        send_random(300, 1'b1);
        wait_idle();
    endtask

    task automatic test_step_sweep();
        logic [lmsfir_pkg::MuW-1:0] steps [5];
        steps[0] = 24'h000000;
        steps[1] = 24'h000001;
        steps[2] = 24'hffffff;
        steps[3] = lmsfir_pkg::MuW'($urandom_range(4095, 1));
        steps[4] = lmsfir_pkg::MuW'($urandom);
        foreach (steps[i]) begin
            write_step(steps[i]);
            send_random(120, 1'b1);
            wait_idle();
        end
    endtask

    // receiver holds off while beats keep coming, so the input stalls
    task automatic test_backpressure();
        write_step(lmsfir_pkg::StepReset);
        tx_idle_on     = 1'b0;
        rx_hold_cycles = HOLD_CYCLES;
        for (int i = 0; i < 40; i++) begin
            send_beat(draw_span(9), draw_span(9));
        end
        tx_idle_on = 1'b1;
        wait_idle();
    endtask

    task automatic test_no_idle();
        write_step(lmsfir_pkg::MuW'($urandom_range(8191, 1)));
        send_random(200, 1'b0);
        wait_idle();
    endtask

    task automatic test_random_steps();
        repeat (2) begin
            write_step(lmsfir_pkg::MuW'($urandom));
            send_random(50, 1'b1);
            wait_idle();
        end
    endtask

    // ------------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------------
    initial begin
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_sample       = '0;
        i_desired      = '0;
        i_cfg_we       = 1'b0;
        i_cfg_wdata    = '0;
        tx_idle_on     = 1'b1;
        rx_idle_on     = 1'b1;
        rx_hold_cycles = 0;
        fail_count     = 0;
        beats_out      = 0;
        quiet_cycles   = 0;
        clear_filter_state();
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_extremes();
        test_saturation();
        test_reset_step_random();
        test_step_sweep();
        test_backpressure();
        test_no_idle();
        test_random_steps();

        if (due_results.size() != 0) begin
            report_mismatch("results never delivered, count", due_results.size(), 0);
        end
        if (fail_count == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

endmodule
